// ----- sv/mkog_pkg.sv -----
// Shared types and constants for the matrix key order generator.
package mkog_pkg;

	localparam int KEY_W      = 32;
	localparam int CFG_SIDE_W = 17;
	localparam int PERIOD_W   = 32;
	localparam int MODE_W     = 2;
	localparam int REG_IDX_W  = 2;
	localparam int DIV_CNT_W  = 5;

	localparam logic [MODE_W-1:0] MODE_ROW   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COL   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_INTER = 2'd2;

	localparam logic [REG_IDX_W-1:0] REG_ORDER_MODE  = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_MATRIX_SIDE = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_KEEP_PERIOD = 2'd2;

	localparam logic [DIV_CNT_W-1:0] DIV_LAST = 5'd31;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_MUL,
		ST_DIV,
		ST_OUT
	} state_t;

endpackage

// ----- sv/matrix_key_order_generator.sv -----
// Top level of the matrix key order generator with its sequencer and divider.
//
// The block walks every position of a square matrix in row-major, column-major or
// interleaved order and delivers one word per input word. An input word carries
// restart: 1 begins the walk at the first position, 0 takes the pending position.
// Each output word carries key (row times side plus column), keep (key is a
// multiple of keep_period) and last (final position of the walk).
// Both channels use valid and stall; a word moves when valid is high and stall low.
// Registers order_mode, matrix_side and keep_period sit at byte addresses 0, 4
// and 8 of the APB port. The user must write them only while the block is idle;
// the block itself does not enforce this. A word passes the key multiply in
// ST_MUL, the restoring divider in ST_DIV that forms key modulo keep_period one
// quotient bit per cycle, and ST_OUT, which moves the result into the output
// register. The output word becomes valid in the same cycle that in_stall drops,
// so a new input word is accepted only after the last one has left the sequencer.
// in_stall is high while a word is in the sequencer. When the receiver stalls,
// the output register holds its word and a finished result waits in the
// sequencer until the register frees up. Reset returns the registers to
// row-major, side 1 and period 1, empties the output and sets the walk to its
// first position.
module matrix_key_order_generator #(
	parameter int MAX_SIDE = 65536
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [3:0]                         paddr,
	input  logic [31:0]                        pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  logic                               restart,
	output logic                               out_valid,
	input  logic                               out_stall,
	output logic [mkog_pkg::KEY_W-1:0]         key,
	output logic                               keep,
	output logic                               last
);

	localparam int SIDE_W = $clog2(MAX_SIDE + 1);
	localparam int PROD_W = 2 * SIDE_W;
	localparam logic [mkog_pkg::CFG_SIDE_W-1:0] MAX_SIDE_C = mkog_pkg::CFG_SIDE_W'(MAX_SIDE);

	logic [mkog_pkg::MODE_W-1:0]     order_mode_q;
	logic [mkog_pkg::CFG_SIDE_W-1:0] matrix_side_q;
	logic [mkog_pkg::PERIOD_W-1:0]   keep_period_q;

	logic [SIDE_W-1:0] outer_q;
	logic [SIDE_W-1:0] inner_q;
	logic              phase_q;

	logic [SIDE_W-1:0] row_q;
	logic [SIDE_W-1:0] col_q;
	logic              last_q;

	logic [mkog_pkg::KEY_W-1:0]    key_q;
	logic [mkog_pkg::KEY_W-1:0]    dividend_q;
	logic [mkog_pkg::PERIOD_W-1:0] rem_q;
	logic [mkog_pkg::DIV_CNT_W-1:0] cnt_q;

	logic                          out_valid_q;
	logic [mkog_pkg::KEY_W-1:0]    out_key_q;
	logic                          out_keep_q;
	logic                          out_last_q;

	mkog_pkg::state_t state_q;
	mkog_pkg::state_t state_d;

	logic                          cfg_wr;
	logic [mkog_pkg::REG_IDX_W-1:0] reg_idx;
	logic [mkog_pkg::CFG_SIDE_W-1:0] side_clamp;
	logic [SIDE_W-1:0]             side_eff;
	logic [SIDE_W-1:0]             side_m1;
	logic                          inter;
	logic                          pos_ok;
	logic                          accept;
	logic                          out_free;
	logic                          load_out;
	logic [SIDE_W-1:0]             cur_outer;
	logic [SIDE_W-1:0]             cur_inner;
	logic                          cur_phase;
	logic [SIDE_W-1:0]             cur_row;
	logic [SIDE_W-1:0]             cur_col;
	logic                          cur_last;
	logic [SIDE_W-1:0]             nxt_outer;
	logic [SIDE_W-1:0]             nxt_inner;
	logic                          nxt_phase;
	logic [PROD_W-1:0]             prod;
	logic [mkog_pkg::PERIOD_W:0]   trial;
	logic [mkog_pkg::PERIOD_W:0]   trial_sub;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = paddr[3:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q  <= mkog_pkg::MODE_ROW;
			matrix_side_q <= mkog_pkg::CFG_SIDE_W'(1);
			keep_period_q <= mkog_pkg::PERIOD_W'(1);
		end else if (cfg_wr) begin
			case (reg_idx)
				mkog_pkg::REG_ORDER_MODE:  order_mode_q  <= pwdata[mkog_pkg::MODE_W-1:0];
				mkog_pkg::REG_MATRIX_SIDE: matrix_side_q <= pwdata[mkog_pkg::CFG_SIDE_W-1:0];
				mkog_pkg::REG_KEEP_PERIOD: keep_period_q <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			mkog_pkg::REG_ORDER_MODE:  prdata = 32'(order_mode_q);
			mkog_pkg::REG_MATRIX_SIDE: prdata = 32'(matrix_side_q);
			mkog_pkg::REG_KEEP_PERIOD: prdata = keep_period_q;
			default:                   prdata = '0;
		endcase
	end

	always_comb begin
		side_clamp = matrix_side_q;
		if (side_clamp == '0) begin
			side_clamp = mkog_pkg::CFG_SIDE_W'(1);
		end
		if (side_clamp > MAX_SIDE_C) begin
			side_clamp = MAX_SIDE_C;
		end
		side_eff = SIDE_W'(side_clamp);
		side_m1  = side_eff - SIDE_W'(1);
		inter    = (order_mode_q == mkog_pkg::MODE_INTER);
	end

	// Position check, emitted position and the step to the next one.
	always_comb begin
		pos_ok = (outer_q < side_eff) && (inner_q < side_eff);
		if (inter) begin
			if (phase_q && outer_q == '0) begin
				pos_ok = 1'b0;
			end
			if (outer_q != '0 && inner_q < outer_q) begin
				pos_ok = 1'b0;
			end
		end
		if (restart || !pos_ok) begin
			cur_outer = '0;
			cur_inner = '0;
			cur_phase = 1'b0;
		end else begin
			cur_outer = outer_q;
			cur_inner = inner_q;
			cur_phase = phase_q;
		end

		if (order_mode_q == mkog_pkg::MODE_COL) begin
			cur_row = cur_inner;
			cur_col = cur_outer;
		end else if (inter && cur_phase) begin
			cur_row = cur_inner;
			cur_col = cur_outer - SIDE_W'(1);
		end else begin
			cur_row = cur_outer;
			cur_col = cur_inner;
		end

		cur_last = (cur_outer == side_m1) && (cur_inner == side_m1) && (!inter || !cur_phase);

		nxt_outer = cur_outer;
		nxt_inner = cur_inner;
		nxt_phase = cur_phase;
		if (!inter) begin
			nxt_phase = 1'b0;
			if (cur_inner != side_m1) begin
				nxt_inner = cur_inner + SIDE_W'(1);
			end else begin
				nxt_inner = '0;
				nxt_outer = (cur_outer == side_m1) ? '0 : cur_outer + SIDE_W'(1);
			end
		end else if (cur_inner != side_m1) begin
			nxt_inner = cur_inner + SIDE_W'(1);
		end else if (cur_phase) begin
			nxt_phase = 1'b0;
			nxt_inner = cur_outer;
		end else if (cur_outer == side_m1) begin
			nxt_outer = '0;
			nxt_inner = '0;
		end else begin
			nxt_outer = cur_outer + SIDE_W'(1);
			nxt_inner = cur_outer + SIDE_W'(1);
			nxt_phase = 1'b1;
		end
	end

	assign prod      = PROD_W'(row_q) * PROD_W'(side_eff);
	assign trial     = {rem_q, dividend_q[mkog_pkg::KEY_W-1]};
	assign trial_sub = trial - {1'b0, keep_period_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mkog_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		in_stall = (state_q != mkog_pkg::ST_IDLE);
		accept   = in_valid && !in_stall;
		out_free = !out_valid_q || !out_stall;
		load_out = 1'b0;
		case (state_q)
			mkog_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = mkog_pkg::ST_MUL;
				end
			end
			mkog_pkg::ST_MUL: begin
				state_d = mkog_pkg::ST_DIV;
			end
			mkog_pkg::ST_DIV: begin
				if (cnt_q == mkog_pkg::DIV_LAST) begin
					state_d = mkog_pkg::ST_OUT;
				end
			end
			mkog_pkg::ST_OUT: begin
				if (out_free) begin
					load_out = 1'b1;
					state_d  = mkog_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = mkog_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			outer_q <= '0;
			inner_q <= '0;
			phase_q <= 1'b0;
		end else if (accept) begin
			outer_q <= nxt_outer;
			inner_q <= nxt_inner;
			phase_q <= nxt_phase;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (state_q == mkog_pkg::ST_DIV) begin
			cnt_q <= cnt_q + mkog_pkg::DIV_CNT_W'(1);
		end else begin
			cnt_q <= '0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			row_q  <= cur_row;
			col_q  <= cur_col;
			last_q <= cur_last;
		end
		if (state_q == mkog_pkg::ST_MUL) begin
			key_q      <= mkog_pkg::KEY_W'(prod + PROD_W'(col_q));
			dividend_q <= mkog_pkg::KEY_W'(prod + PROD_W'(col_q));
			rem_q      <= '0;
		end else if (state_q == mkog_pkg::ST_DIV) begin
			dividend_q <= {dividend_q[mkog_pkg::KEY_W-2:0], 1'b0};
			if (trial >= {1'b0, keep_period_q}) begin
				rem_q <= trial_sub[mkog_pkg::PERIOD_W-1:0];
			end else begin
				rem_q <= trial[mkog_pkg::PERIOD_W-1:0];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load_out) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_out) begin
			out_key_q  <= key_q;
			out_keep_q <= (rem_q == '0);
			out_last_q <= last_q;
		end
	end

	assign out_valid = out_valid_q;
	assign key       = out_key_q;
	assign keep      = out_keep_q;
	assign last      = out_last_q;

	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q == mkog_pkg::ST_MUL))
		else $error("accepted word did not start the multiply");

	a_div_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mkog_pkg::ST_DIV && cnt_q == mkog_pkg::DIV_LAST)
		|=> (state_q == mkog_pkg::ST_OUT))
		else $error("divider did not finish after 32 steps");

	a_pos_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != mkog_pkg::ST_IDLE) |-> (outer_q < side_eff && inner_q < side_eff))
		else $error("walk position left the matrix");

	a_out_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == mkog_pkg::ST_OUT && out_free) |=> (out_valid && state_q == mkog_pkg::ST_IDLE))
		else $error("finished result was not moved to the output");

endmodule

// ----- tb/testbench.sv -----
// Self-checking testbench for the matrix key order generator: directed plan, then random walks.
module testbench;

	localparam int SIDE_LIMIT = 65536;
	localparam int RANDOM_WORDS = 1400;
	localparam int STALL_LIMIT = 2000;
	localparam logic [mkog_pkg::MODE_W-1:0] MODE_UNUSED = 2'd3;

	typedef struct packed {
		logic [mkog_pkg::KEY_W-1:0] key;
		logic                       keep;
		logic                       last;
	} key_word_t;

	typedef enum logic [1:0] {
		SET_REGS,
		CHECK_TYPED,
		CHECK_PREDICTED
	} step_kind_t;

	typedef struct packed {
		step_kind_t                      kind;
		logic [mkog_pkg::MODE_W-1:0]     mode;
		logic [mkog_pkg::CFG_SIDE_W-1:0] side;
		logic [mkog_pkg::PERIOD_W-1:0]   period;
		logic                            restart;
		key_word_t                       word;
	} plan_step_t;

	logic clk;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [3:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic restart;
	logic out_valid;
	logic out_stall;
	logic [mkog_pkg::KEY_W-1:0] key;
	logic keep;
	logic last;

	logic [mkog_pkg::MODE_W-1:0] order_mode_q;
	logic [mkog_pkg::CFG_SIDE_W-1:0] side_q;
	logic [mkog_pkg::PERIOD_W-1:0] period_q;
	logic [mkog_pkg::CFG_SIDE_W-1:0] walk_outer;
	logic [mkog_pkg::CFG_SIDE_W-1:0] walk_inner;
	logic walk_column_part;

	key_word_t expected_words[$];
	plan_step_t plan[$];
	int unsigned mismatches;
	int unsigned words_sent;
	int unsigned idle_cycles;
	int unsigned stall_left;
	bit no_idle;

	matrix_key_order_generator #(
		.MAX_SIDE(SIDE_LIMIT)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.restart(restart),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.key(key),
		.keep(keep),
		.last(last)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	function automatic int unsigned effective_side();
		if (side_q == '0)
			return 1;
		if (32'(side_q) > SIDE_LIMIT)
			return SIDE_LIMIT;
		return 32'(side_q);
	endfunction

	function automatic key_word_t walk_step(input logic start_over);
		int unsigned side;
		bit interleaved;
		bit in_range;
		logic [63:0] row;
		logic [63:0] col;
		logic [63:0] full_key;
		key_word_t word;
		side = effective_side();
		interleaved = (order_mode_q == mkog_pkg::MODE_INTER);
		in_range = 32'(walk_outer) < side && 32'(walk_inner) < side;
		if (interleaved && walk_column_part && walk_outer == '0)
			in_range = 1'b0;
		if (interleaved && walk_outer != '0 && walk_inner < walk_outer)
			in_range = 1'b0;
		if (start_over || !in_range) begin
			walk_outer = '0;
			walk_inner = '0;
			walk_column_part = 1'b0;
		end
		if (order_mode_q == mkog_pkg::MODE_COL) begin
			row = 64'(walk_inner);
			col = 64'(walk_outer);
		end else if (interleaved && walk_column_part) begin
			row = 64'(walk_inner);
			col = 64'(walk_outer) - 64'd1;
		end else begin
			row = 64'(walk_outer);
			col = 64'(walk_inner);
		end
		full_key = row * 64'(side) + col;
		word.key = full_key[mkog_pkg::KEY_W-1:0];
		if (period_q == '0)
			word.keep = (word.key == '0);
		else
			word.keep = (word.key % period_q) == '0;
		word.last = 32'(walk_outer) == side - 1 && 32'(walk_inner) == side - 1 &&
			(!interleaved || !walk_column_part);
		if (!interleaved) begin
			walk_column_part = 1'b0;
			if (32'(walk_inner) + 1 < side) begin
				walk_inner = walk_inner + 1'b1;
			end else begin
				walk_inner = '0;
				walk_outer = walk_outer + 1'b1;
				if (32'(walk_outer) >= side)
					walk_outer = '0;
			end
		end else if (32'(walk_inner) + 1 < side) begin
			walk_inner = walk_inner + 1'b1;
		end else if (walk_column_part) begin
			walk_column_part = 1'b0;
			walk_inner = walk_outer;
		end else begin
			walk_outer = walk_outer + 1'b1;
			if (32'(walk_outer) >= side) begin
				walk_outer = '0;
				walk_inner = '0;
			end else begin
				walk_column_part = 1'b1;
				walk_inner = walk_outer;
			end
		end
		return word;
	endfunction

	function automatic int unsigned idle_length();
		int unsigned r;
		r = $urandom_range(99);
		if (no_idle || r < 50)
			return 0;
		if (r < 85)
			return $urandom_range(1, 3);
		if (r < 97)
			return $urandom_range(4, 10);
		return $urandom_range(20, 60);
	endfunction

	task automatic report(input string msg);
		mismatches++;
		if (mismatches <= 200)
			$display("ERROR at %0t: %s", $time, msg);
	endtask

	task automatic plan_regs(input logic [mkog_pkg::MODE_W-1:0] mode,
			input logic [mkog_pkg::CFG_SIDE_W-1:0] side,
			input logic [mkog_pkg::PERIOD_W-1:0] period);
		plan.push_back('{SET_REGS, mode, side, period, 1'b0, '0});
	endtask

	task automatic plan_word(input step_kind_t kind, input logic start_over,
			input logic [mkog_pkg::KEY_W-1:0] want_key, input logic want_keep,
			input logic want_last);
		plan.push_back('{kind, mkog_pkg::MODE_ROW, '0, '0, start_over,
			'{want_key, want_keep, want_last}});
	endtask

	task automatic apb_write(input logic [mkog_pkg::REG_IDX_W-1:0] idx, input logic [31:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (pready !== 1'b1)
			@(posedge clk);
	endtask

	task automatic write_registers(input logic [2:0] which,
			input logic [mkog_pkg::MODE_W-1:0] mode,
			input logic [mkog_pkg::CFG_SIDE_W-1:0] side,
			input logic [mkog_pkg::PERIOD_W-1:0] period);
		if (which[0]) begin
			apb_write(mkog_pkg::REG_ORDER_MODE, {{(32-mkog_pkg::MODE_W){1'b0}}, mode});
			order_mode_q = mode;
		end
		if (which[1]) begin
			apb_write(mkog_pkg::REG_MATRIX_SIDE, {{(32-mkog_pkg::CFG_SIDE_W){1'b0}}, side});
			side_q = side;
		end
		if (which[2]) begin
			apb_write(mkog_pkg::REG_KEEP_PERIOD, period);
			period_q = period;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	task automatic send_word(input logic start_over, input bit typed, input key_word_t typed_word);
		int unsigned gap;
		key_word_t predicted;
		gap = idle_length();
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		restart <= start_over;
		@(posedge clk);
		while (in_stall !== 1'b0)
			@(posedge clk);
		predicted = walk_step(start_over);
		expected_words.push_back(typed ? typed_word : predicted);
		words_sent++;
	endtask

	task automatic finish_words();
		in_valid <= 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	always @(posedge clk) begin : check_output
		key_word_t want;
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0) begin
			if (expected_words.size() == 0) begin
				report($sformatf("unexpected word with key %0h", key));
			end else begin
				want = expected_words.pop_front();
				if (key !== want.key)
					report($sformatf("key %0h, expected %0h", key, want.key));
				if (keep !== want.keep)
					report($sformatf("keep %b for key %0h, expected %b", keep, want.key,
						want.keep));
				if (last !== want.last)
					report($sformatf("last %b for key %0h, expected %b", last, want.key,
						want.last));
			end
		end
	end

	always @(posedge clk) begin
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left <= stall_left - 1;
		end else begin
			out_stall <= 1'b0;
			if ($urandom_range(2) == 0)
				stall_left <= idle_length();
		end
	end

	always @(posedge clk) begin
		if ((in_valid === 1'b1 && in_stall === 1'b0) ||
				(out_valid === 1'b1 && out_stall === 1'b0) ||
				(psel && penable && pwrite && pready === 1'b1))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		int unsigned random_start;
		int unsigned count;
		int unsigned r;
		int unsigned side;
		logic [mkog_pkg::MODE_W-1:0] mode;
		logic [mkog_pkg::CFG_SIDE_W-1:0] side_value;
		logic [mkog_pkg::PERIOD_W-1:0] period;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		out_stall = 1'b0;
		stall_left = 0;
		idle_cycles = 0;
		mismatches = 0;
		words_sent = 0;
		no_idle = 1'b0;
		order_mode_q = mkog_pkg::MODE_ROW;
		side_q = 1;
		period_q = 1;
		walk_outer = '0;
		walk_inner = '0;
		walk_column_part = 1'b0;

		plan_word(CHECK_TYPED, 1'b0, 32'd0, 1'b1, 1'b1);
		plan_word(CHECK_TYPED, 1'b1, 32'd0, 1'b1, 1'b1);
		plan_regs(mkog_pkg::MODE_ROW, 17'd2, 32'd2);
		plan_word(CHECK_TYPED, 1'b0, 32'd0, 1'b1, 1'b0);
		plan_word(CHECK_TYPED, 1'b0, 32'd1, 1'b0, 1'b0);
		plan_word(CHECK_TYPED, 1'b0, 32'd2, 1'b1, 1'b0);
		plan_word(CHECK_TYPED, 1'b0, 32'd3, 1'b0, 1'b1);
		plan_regs(mkog_pkg::MODE_COL, 17'd2, 32'd0);
		plan_word(CHECK_TYPED, 1'b0, 32'd0, 1'b1, 1'b0);
		plan_word(CHECK_TYPED, 1'b0, 32'd2, 1'b0, 1'b0);
		plan_word(CHECK_TYPED, 1'b1, 32'd0, 1'b1, 1'b0);
		plan_regs(mkog_pkg::MODE_INTER, 17'd3, 32'd3);
		plan_word(CHECK_PREDICTED, 1'b1, '0, 1'b0, 1'b0);
		repeat (6) plan_word(CHECK_PREDICTED, 1'b0, '0, 1'b0, 1'b0);
		plan_regs(mkog_pkg::MODE_INTER, 17'd2, 32'd3);
		plan_word(CHECK_PREDICTED, 1'b0, '0, 1'b0, 1'b0);
		plan_regs(MODE_UNUSED, 17'd0, 32'hFFFF_FFFF);
		plan_word(CHECK_TYPED, 1'b0, 32'd0, 1'b1, 1'b1);
		plan_word(CHECK_PREDICTED, 1'b0, '0, 1'b0, 1'b0);
		plan_regs(mkog_pkg::MODE_ROW, 17'h1FFFF, 32'd65536);
		plan_word(CHECK_TYPED, 1'b0, 32'd0, 1'b1, 1'b0);
		plan_word(CHECK_TYPED, 1'b0, 32'd1, 1'b0, 1'b0);
		plan_regs(mkog_pkg::MODE_COL, 17'd65536, 32'd0);
		repeat (2) plan_word(CHECK_PREDICTED, 1'b0, '0, 1'b0, 1'b0);
		plan_regs(mkog_pkg::MODE_INTER, 17'd65536, 32'd1);
		repeat (2) plan_word(CHECK_PREDICTED, 1'b0, '0, 1'b0, 1'b0);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			if (plan[i].kind == SET_REGS) begin
				finish_words();
				write_registers(3'b111, plan[i].mode, plan[i].side, plan[i].period);
			end else begin
				send_word(plan[i].restart, plan[i].kind == CHECK_TYPED, plan[i].word);
			end
		end

		random_start = words_sent;
		while (words_sent - random_start < RANDOM_WORDS) begin
			finish_words();
			no_idle = ($urandom_range(5) == 0);
			r = $urandom_range(9);
			mode = r < 3 ? mkog_pkg::MODE_ROW :
				r < 6 ? mkog_pkg::MODE_COL :
				r < 9 ? mkog_pkg::MODE_INTER : MODE_UNUSED;
			r = $urandom_range(19);
			case (r)
				0: side_value = 17'd0;
				1: side_value = 17'd1;
				2: side_value = 17'd65536;
				3: side_value = mkog_pkg::CFG_SIDE_W'($urandom_range(65537, 131071));
				4: side_value = mkog_pkg::CFG_SIDE_W'($urandom_range(1, 65536));
				default: side_value = mkog_pkg::CFG_SIDE_W'($urandom_range(2, 7));
			endcase
			r = $urandom_range(9);
			case (r)
				0: period = 32'd0;
				1: period = 32'd1;
				2: period = 32'hFFFF_FFFF;
				3: period = $urandom();
				default: period = $urandom_range(2, 9);
			endcase
			write_registers(3'($urandom_range(1, 7)), mode, side_value, period);
			side = effective_side();
			if (side <= 7)
				count = $urandom_range(1, 2 * side * side + 2);
			else
				count = $urandom_range(1, 40);
			repeat (count)
				send_word($urandom_range(39) == 0, 1'b0, '0);
		end

		finish_words();
		repeat (40) @(posedge clk);
		if (expected_words.size() != 0)
			report($sformatf("%0d words never arrived", expected_words.size()));
		if (mismatches == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
